// ----- hw/rtl/msr_pkg.sv -----
// Package for the matrix store with rotation.
// Holds the item, result and command types and the queue constants.
// No dependencies.
package msr_pkg;

  localparam int DIM_W    = 7;
  localparam int IDX_W    = 6;
  localparam int ELEM_W   = 8;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;
  localparam int QCNT_W   = 2;

  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_FILL      = 3'd2,
    OP_CLEAR     = 3'd3,
    OP_CREATE    = 3'd4,
    OP_ROT_LEFT  = 3'd5,
    OP_ROT_RIGHT = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SWEEP = 2'd2,
    CMD_REPLY = 2'd3
  } cmd_kind_e;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_SWEEP = 1'b1
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [ELEM_W-1:0] value;
    logic [DIM_W-1:0]  new_rows;
    logic [DIM_W-1:0]  new_cols;
  } item_t;

  typedef struct packed {
    logic [ELEM_W-1:0] data;
    logic              ok;
  } result_t;

  // For a sweep, prow and pcol carry the extent of the region to walk.
  typedef struct packed {
    cmd_kind_e         kind;
    logic [DIM_W-1:0]  prow;
    logic [DIM_W-1:0]  pcol;
    logic [ELEM_W-1:0] value;
    logic              ok;
  } cmd_t;

endpackage

// ----- hw/rtl/matrix_store_with_rotation_top.sv -----
// Top level of the matrix store with rotation: front part, command queue and
// back part with the element store.
// Depends on msr_pkg, msr_front, msr_fifo and msr_back.
//
// An item (one operation) is taken at a rising edge with start high and busy
// low. Every item gives one result, shown on result_o for one cycle with
// valid_o high; the receiver must take it then, and results come in item
// order. Rotations are done by remapping addresses, so read, write, rotate
// and rejected items need no walk in the back part and, while the queue
// holds them, follow one another every cycle. With the queue empty and the
// back part idle, a taken item passes through a queue entry and then the
// back part's result registers. Fill, clear and create walk the stored
// region one element per cycle through the single write port. Busy rises
// while the two-entry queue is full, typically behind such a walk.
// Reset empties the queue and sets the matrix to none (zero rows and
// columns); the element store itself is not cleared, and an accepted create
// zeroes its region.
module matrix_store_with_rotation_top
  import msr_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  item_t   item_i,
  output logic    busy,
  output logic    valid_o,
  output result_t result_o
);

  logic push, pop, full, empty, back_busy;
  cmd_t cmd_in, cmd_out;

  msr_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .item_i (item_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  msr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .cmd_o  (cmd_out),
    .full_o (full),
    .empty_o(empty)
  );

  msr_back #(
    .MAX_DIM(MAX_DIM)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_out),
    .empty_i (empty),
    .pop_o   (pop),
    .busy_o  (back_busy),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  assign busy = full;

`ifndef ASSERT_OFF
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && cmd_out.kind == CMD_READ |=> valid_o && result_o.ok)
    else $error("read command gave no result in the next cycle");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !result_o.ok |-> result_o.data == '0)
    else $error("rejected item returned non-zero data");

  a_reply_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && empty && !back_busy && cmd_in.kind == CMD_REPLY |=> ##1 valid_o)
    else $error("reply item not delivered two cycles after acceptance");
`endif

endmodule

// ----- hw/rtl/msr_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module msr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/msr_fifo.sv -----
// Two-entry command queue between the front and back parts.
// Depends on msr_pkg.
module msr_fifo
  import msr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wp_q, wp_d;
  logic [QPTR_W-1:0] rp_q, rp_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = do_push ? wp_q + 1'b1 : wp_q;
    rp_d  = do_pop ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/msr_front.sv -----
// Front part: accepts items, checks them against the matrix dimensions and
// orientation, and turns them into commands on physical coordinates.
// Depends on msr_pkg.
module msr_front
  import msr_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  item_t item_i,
  input  logic  full_i,
  output logic  push_o,
  output cmd_t  cmd_o
);

  // Dimensions are those of the stored (unrotated) matrix.
  logic [DIM_W-1:0] rows_q, rows_d;
  logic [DIM_W-1:0] cols_q, cols_d;
  logic [1:0]       orient_q, orient_d;

  logic [DIM_W-1:0] lrows, lcols, r7, c7, pr_m, pc_m, prow, pcol;
  logic             accept, in_range, have, create_ok;

  always_comb begin
    accept    = start_i && !full_i;
    lrows     = orient_q[0] ? cols_q : rows_q;
    lcols     = orient_q[0] ? rows_q : cols_q;
    r7        = {1'b0, item_i.row};
    c7        = {1'b0, item_i.col};
    pr_m      = rows_q - DIM_W'(1);
    pc_m      = cols_q - DIM_W'(1);
    in_range  = (r7 < lrows) && (c7 < lcols);
    have      = (rows_q != '0) && (cols_q != '0);
    create_ok = (item_i.new_rows != '0) && (item_i.new_cols != '0) &&
                (32'(item_i.new_rows) <= 32'(MAX_DIM)) &&
                (32'(item_i.new_cols) <= 32'(MAX_DIM));

    unique case (orient_q)
      2'd0: begin
        prow = r7;
        pcol = c7;
      end
      2'd1: begin
        prow = pr_m - c7;
        pcol = r7;
      end
      2'd2: begin
        prow = pr_m - r7;
        pcol = pc_m - c7;
      end
      default: begin
        prow = c7;
        pcol = pc_m - r7;
      end
    endcase

    rows_d      = rows_q;
    cols_d      = cols_q;
    orient_d    = orient_q;
    cmd_o.kind  = CMD_REPLY;
    cmd_o.prow  = '0;
    cmd_o.pcol  = '0;
    cmd_o.value = '0;
    cmd_o.ok    = 1'b0;

    unique case (item_i.op)
      OP_READ: begin
        if (in_range) begin
          cmd_o.kind = CMD_READ;
          cmd_o.prow = prow;
          cmd_o.pcol = pcol;
        end
      end
      OP_WRITE: begin
        if (in_range) begin
          cmd_o.kind  = CMD_WRITE;
          cmd_o.prow  = prow;
          cmd_o.pcol  = pcol;
          cmd_o.value = item_i.value;
        end
      end
      OP_FILL: begin
        if (have) begin
          cmd_o.kind  = CMD_SWEEP;
          cmd_o.prow  = rows_q;
          cmd_o.pcol  = cols_q;
          cmd_o.value = item_i.value;
        end
      end
      OP_CLEAR: begin
        if (have) begin
          cmd_o.kind = CMD_SWEEP;
          cmd_o.prow = rows_q;
          cmd_o.pcol = cols_q;
        end
      end
      OP_CREATE: begin
        if (create_ok) begin
          cmd_o.kind = CMD_SWEEP;
          cmd_o.prow = item_i.new_rows;
          cmd_o.pcol = item_i.new_cols;
          rows_d     = item_i.new_rows;
          cols_d     = item_i.new_cols;
          orient_d   = 2'd0;
        end
      end
      OP_ROT_LEFT: begin
        if (have) begin
          cmd_o.ok = 1'b1;
          orient_d = orient_q - 2'd1;
        end
      end
      OP_ROT_RIGHT: begin
        if (have) begin
          cmd_o.ok = 1'b1;
          orient_d = orient_q + 2'd1;
        end
      end
      default: begin
        cmd_o.kind = CMD_REPLY;
      end
    endcase
  end

  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= '0;
      cols_q   <= '0;
      orient_q <= '0;
    end else if (accept) begin
      rows_q   <= rows_d;
      cols_q   <= cols_d;
      orient_q <= orient_d;
    end
  end

endmodule

// ----- hw/rtl/msr_back.sv -----
// Back part: carries out queued commands on the element store, walking the
// store for sweeps, and drives the result strobe.
// Depends on msr_pkg and msr_ram.
module msr_back
  import msr_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  logic    empty_i,
  output logic    pop_o,
  output logic    busy_o,
  output logic    valid_o,
  output result_t result_o
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  back_state_e       st_q, st_d;
  logic [DIM_W-1:0]  r_q, r_d, c_q, c_d, lr_q, lr_d, lc_q, lc_d;
  logic [ELEM_W-1:0] val_q, val_d, data_q, data_d;
  logic              done_q, done_d, rd_q, rd_d, ok_q, ok_d;
  logic [DIM_W-1:0]  ar, ac;
  logic [AW-1:0]     addr;
  logic              we;
  logic [ELEM_W-1:0] wdata, rdata;
  logic              last_c;

  always_comb begin
    pop_o  = (st_q == BK_IDLE) && !empty_i;
    ar     = (st_q == BK_SWEEP) ? r_q : cmd_i.prow;
    ac     = (st_q == BK_SWEEP) ? c_q : cmd_i.pcol;
    addr   = AW'(ar) * AW'(MAX_DIM) + AW'(ac);
    last_c = (c_q == lc_q - DIM_W'(1));

    st_d   = st_q;
    r_d    = r_q;
    c_d    = c_q;
    lr_d   = lr_q;
    lc_d   = lc_q;
    val_d  = val_q;
    data_d = '0;
    ok_d   = 1'b0;
    done_d = 1'b0;
    rd_d   = 1'b0;
    we     = 1'b0;
    wdata  = val_q;

    unique case (st_q)
      BK_IDLE: begin
        if (pop_o) begin
          unique case (cmd_i.kind)
            CMD_READ: begin
              rd_d = 1'b1;
            end
            CMD_WRITE: begin
              we     = 1'b1;
              wdata  = cmd_i.value;
              done_d = 1'b1;
              data_d = cmd_i.value;
              ok_d   = 1'b1;
            end
            CMD_SWEEP: begin
              st_d  = BK_SWEEP;
              r_d   = '0;
              c_d   = '0;
              lr_d  = cmd_i.prow;
              lc_d  = cmd_i.pcol;
              val_d = cmd_i.value;
            end
            default: begin
              done_d = 1'b1;
              ok_d   = cmd_i.ok;
            end
          endcase
        end
      end
      default: begin
        we = 1'b1;
        if (last_c) begin
          c_d = '0;
          r_d = r_q + DIM_W'(1);
          if (r_q == lr_q - DIM_W'(1)) begin
            st_d   = BK_IDLE;
            done_d = 1'b1;
            ok_d   = 1'b1;
          end
        end else begin
          c_d = c_q + DIM_W'(1);
        end
      end
    endcase
  end

  msr_ram #(
    .WIDTH(ELEM_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(addr),
    .wdata_i(wdata),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    c_q    <= c_d;
    lr_q   <= lr_d;
    lc_q   <= lc_d;
    val_q  <= val_d;
    data_q <= data_d;
    ok_q   <= ok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= BK_IDLE;
      done_q <= 1'b0;
      rd_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
      rd_q   <= rd_d;
    end
  end

  assign busy_o        = (st_q == BK_SWEEP);
  assign valid_o       = done_q || rd_q;
  assign result_o.data = rd_q ? rdata : data_q;
  assign result_o.ok   = rd_q || ok_q;

endmodule
